/* design/vn2d_pkg.sv */
// Shared types and constants of the 2-D value noise pipeline.
// Holds the hash constants, the stage numbering and the stage load vector.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none

package vn2d_pkg;

    localparam int NUM_STAGES = 10;

    // Stage numbers, in the order an item travels.
    localparam int STG_SCALE  = 0;
    localparam int STG_PREMUL = 1;
    localparam int STG_SUM    = 2;
    localparam int STG_MIX1   = 3;
    localparam int STG_MIX2   = 4;
    localparam int STG_CORNER = 5;
    localparam int STG_LERP   = 6;
    localparam int STG_WEIGHT = 7;
    localparam int STG_ROUND  = 8;
    localparam int STG_OUT    = 9;

    typedef logic [NUM_STAGES-1:0] stage_ld_t;

    localparam logic [31:0] HASH_MUL_X    = 32'h8da6b343;
    localparam logic [31:0] HASH_MUL_Z    = 32'hd8163841;
    localparam logic [31:0] HASH_MUL_SALT = 32'hcb1ab31f;
    localparam logic [31:0] HASH_MIX_1    = 32'h2c1b3c6d;
    localparam logic [31:0] HASH_MIX_2    = 32'h297a2d39;

    localparam logic [23:0] CORNER_MAX = 24'hffffff;
    localparam logic [16:0] FRAC_ONE   = 17'h10000;
    localparam logic [17:0] SMOOTH_K3  = 18'd196608;
    localparam logic [39:0] ROUND_HALF = 40'd8388607;

    typedef logic [15:0] frac_t;
    typedef logic [1:0][15:0] frac_pair_t;
    typedef logic [3:0][23:0] corner_set_t;

endpackage

`default_nettype wire

/* design/vn2d_lattice.sv */
// Lattice mapping: scales the sample point, splits it into cell indices and
// fractions, and smooths the fractions with 3t^2 - 2t^3. Uses vn2d_pkg.
// Fractions leave aligned with the corner stage of the hash.
`default_nettype none

module vn2d_lattice (
    input  wire logic                aclk,
    input  wire vn2d_pkg::stage_ld_t ld,
    input  wire logic signed [23:0]  pos_x,
    input  wire logic signed [23:0]  pos_z,
    input  wire logic [19:0]         inv_cell,
    input  wire logic [31:0]         salt,
    output logic [31:0]              cell_x,
    output logic [31:0]              cell_z,
    output logic [31:0]              salt_out,
    output vn2d_pkg::frac_pair_t     smooth
);

    logic signed [44:0] prod_x;
    logic signed [44:0] prod_z;
    logic [1:0][43:0]   scaled_reg;
    logic [31:0]        salt_reg;
    logic [1:0][15:0]   frac;
    logic [1:0][31:0]   sq_reg;
    logic [1:0][17:0]   k_reg;
    logic [1:0][49:0]   sm_prod;
    vn2d_pkg::frac_pair_t s2_reg;
    vn2d_pkg::frac_pair_t s3_reg;
    vn2d_pkg::frac_pair_t s4_reg;
    vn2d_pkg::frac_pair_t s5_reg;

    assign prod_x = pos_x * $signed({1'b0, inv_cell});
    assign prod_z = pos_z * $signed({1'b0, inv_cell});

    always_ff @(posedge aclk) begin
        if (ld[vn2d_pkg::STG_SCALE]) begin
            scaled_reg[0] <= prod_x[43:0];
            scaled_reg[1] <= prod_z[43:0];
            salt_reg      <= salt;
        end
    end

    // The cell index is the floor of the product; it is sign extended to 32 bits.
    assign cell_x   = {{12{scaled_reg[0][43]}}, scaled_reg[0][43:24]};
    assign cell_z   = {{12{scaled_reg[1][43]}}, scaled_reg[1][43:24]};
    assign salt_out = salt_reg;

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            frac[a]    = scaled_reg[a][23:8];
            sm_prod[a] = {18'b0, sq_reg[a]} * {32'b0, k_reg[a]};
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[vn2d_pkg::STG_PREMUL]) begin
            for (int a = 0; a < 2; a++) begin
                sq_reg[a] <= {16'b0, frac[a]} * {16'b0, frac[a]};
                k_reg[a]  <= vn2d_pkg::SMOOTH_K3 - {1'b0, frac[a], 1'b0};
            end
        end
        if (ld[vn2d_pkg::STG_SUM]) begin
            for (int a = 0; a < 2; a++) begin
                s2_reg[a] <= sm_prod[a][47:32];
            end
        end
        if (ld[vn2d_pkg::STG_MIX1]) begin
            s3_reg <= s2_reg;
        end
        if (ld[vn2d_pkg::STG_MIX2]) begin
            s4_reg <= s3_reg;
        end
        if (ld[vn2d_pkg::STG_CORNER]) begin
            s5_reg <= s4_reg;
        end
    end

    assign smooth = s5_reg;

endmodule

`default_nettype wire

/* design/vn2d_hash.sv */
// Corner hash: salted three-multiply hash with xorshift mixing for the four
// corners of a cell. Uses vn2d_pkg.
// Corner order is (x,z), (x+1,z), (x,z+1), (x+1,z+1).
`default_nettype none

module vn2d_hash (
    input  wire logic                aclk,
    input  wire vn2d_pkg::stage_ld_t ld,
    input  wire logic [31:0]         cell_x,
    input  wire logic [31:0]         cell_z,
    input  wire logic [31:0]         salt,
    output vn2d_pkg::corner_set_t    corners
);

    logic [31:0]      mx_reg;
    logic [31:0]      mz_reg;
    logic [31:0]      ms_reg;
    logic [3:0][31:0] sum;
    logic [3:0][31:0] sum_reg;
    logic [3:0][31:0] mix1;
    logic [3:0][31:0] mix1_reg;
    logic [3:0][31:0] mix2;
    logic [3:0][31:0] mix2_reg;
    logic [3:0][31:0] fin;
    vn2d_pkg::corner_set_t corner_reg;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            sum[c] = (c[0] ? mx_reg + vn2d_pkg::HASH_MUL_X : mx_reg)
                   + (c[1] ? mz_reg + vn2d_pkg::HASH_MUL_Z : mz_reg)
                   + ms_reg;
            mix1[c] = (sum_reg[c] ^ (sum_reg[c] >> 15)) * vn2d_pkg::HASH_MIX_1;
            mix2[c] = (mix1_reg[c] ^ (mix1_reg[c] >> 12)) * vn2d_pkg::HASH_MIX_2;
            fin[c]  = mix2_reg[c] ^ (mix2_reg[c] >> 15);
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[vn2d_pkg::STG_PREMUL]) begin
            mx_reg <= cell_x * vn2d_pkg::HASH_MUL_X;
            mz_reg <= cell_z * vn2d_pkg::HASH_MUL_Z;
            ms_reg <= salt * vn2d_pkg::HASH_MUL_SALT;
        end
        if (ld[vn2d_pkg::STG_SUM]) begin
            sum_reg <= sum;
        end
        if (ld[vn2d_pkg::STG_MIX1]) begin
            mix1_reg <= mix1;
        end
        if (ld[vn2d_pkg::STG_MIX2]) begin
            mix2_reg <= mix2;
        end
        if (ld[vn2d_pkg::STG_CORNER]) begin
            for (int c = 0; c < 4; c++) begin
                corner_reg[c] <= fin[c][23:0];
            end
        end
    end

    assign corners = corner_reg;

endmodule

`default_nettype wire

/* design/vn2d_blend.sv */
// Bilinear blend of the four corner values and rescale to unsigned Q0.16.
// Uses vn2d_pkg; corner values and fractions arrive from the corner stage.
// The divide by 2^24-1 is a shift, a subtract, three adds and one compare.
`default_nettype none

module vn2d_blend (
    input  wire logic                  aclk,
    input  wire vn2d_pkg::stage_ld_t   ld,
    input  wire vn2d_pkg::corner_set_t corners,
    input  wire vn2d_pkg::frac_pair_t  smooth,
    output logic [15:0]                noise_value
);

    logic [16:0] wx0;
    logic [16:0] wz0;
    logic [40:0] lo_sum;
    logic [40:0] hi_sum;
    logic [39:0] lo_reg;
    logic [39:0] hi_reg;
    logic [15:0] sz_reg;
    logic [56:0] plo_reg;
    logic [56:0] phi_reg;
    logic [56:0] acc;
    logic [23:0] w_reg;
    logic [39:0] scaled;
    logic [15:0] q0;
    logic [24:0] rem;
    logic [15:0] quot;
    logic [15:0] noise_reg;

    assign wx0 = vn2d_pkg::FRAC_ONE - {1'b0, smooth[0]};
    assign wz0 = vn2d_pkg::FRAC_ONE - {1'b0, sz_reg};

    assign lo_sum = {17'b0, corners[0]} * {24'b0, wx0}
                  + {17'b0, corners[1]} * {25'b0, smooth[0]};
    assign hi_sum = {17'b0, corners[2]} * {24'b0, wx0}
                  + {17'b0, corners[3]} * {25'b0, smooth[0]};

    assign acc = plo_reg + phi_reg + 57'h80000000;

    // Rounded quotient by 2^24-1: the remainder after the shift stays below twice the divisor.
    assign scaled = {w_reg, 16'b0} - {16'b0, w_reg} + vn2d_pkg::ROUND_HALF;
    assign q0     = scaled[39:24];
    assign rem    = {1'b0, scaled[23:0]} + {9'b0, q0};
    assign quot   = q0 + {15'b0, (rem >= {1'b0, vn2d_pkg::CORNER_MAX})};

    always_ff @(posedge aclk) begin
        if (ld[vn2d_pkg::STG_LERP]) begin
            lo_reg <= lo_sum[39:0];
            hi_reg <= hi_sum[39:0];
            sz_reg <= smooth[1];
        end
        if (ld[vn2d_pkg::STG_WEIGHT]) begin
            plo_reg <= {17'b0, lo_reg} * {40'b0, wz0};
            phi_reg <= {17'b0, hi_reg} * {41'b0, sz_reg};
        end
        if (ld[vn2d_pkg::STG_ROUND]) begin
            w_reg <= acc[56] ? vn2d_pkg::CORNER_MAX : acc[55:32];
        end
        if (ld[vn2d_pkg::STG_OUT]) begin
            noise_reg <= quot;
        end
    end

    assign noise_value = noise_reg;

endmodule

`default_nettype wire

/* design/value_noise_2d.sv */
// Two-dimensional smoothed value noise, one sample per transaction.
// Input transaction: s_pos_x, s_pos_z (signed Q15.8), s_inv_cell (Q4.16) and
// s_salt, accepted when s_valid and s_ready are both high. Result transaction:
// m_noise_value (unsigned Q0.16), delivered when m_valid and m_ready are high.
// The datapath is a ten-stage pipeline: lattice scaling, hash premultiply,
// hash sum, two mixing multiplies, corner extraction, two blend multiplies,
// rounding and the final rescale. While the receiver keeps m_ready high, a new
// sample can be accepted in every cycle, so throughput is one transaction per
// clock.
// Every stage carries a valid bit and loads whenever it is empty or its
// successor loads. When the receiver holds m_ready low, the result stays on
// the output and the stages behind it keep filling empty slots; s_ready only
// falls once every stage holds a sample.
// The synchronous, active-low aresetn clears all valid bits; nothing else needs
// clearing, and the block is ready in the first cycle after reset.
// Uses vn2d_pkg, vn2d_lattice, vn2d_hash and vn2d_blend.
`default_nettype none

module value_noise_2d (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [23:0] s_pos_x,
    input  wire logic signed [23:0] s_pos_z,
    input  wire logic [19:0]        s_inv_cell,
    input  wire logic [31:0]        s_salt,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [15:0]             m_noise_value
);

    vn2d_pkg::stage_ld_t   ld;
    vn2d_pkg::stage_ld_t   v_reg;
    vn2d_pkg::stage_ld_t   v_next;
    logic [31:0]           cell_x;
    logic [31:0]           cell_z;
    logic [31:0]           salt_s0;
    vn2d_pkg::frac_pair_t  smooth;
    vn2d_pkg::corner_set_t corners;

    always_comb begin
        ld[vn2d_pkg::STG_OUT] = !v_reg[vn2d_pkg::STG_OUT] || m_ready;
        for (int k = vn2d_pkg::STG_OUT - 1; k >= 0; k--) begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
        v_next[0] = ld[0] ? s_valid : v_reg[0];
        for (int k = 1; k < vn2d_pkg::NUM_STAGES; k++) begin
            v_next[k] = ld[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_ready = ld[0];
    assign m_valid = v_reg[vn2d_pkg::STG_OUT];

    vn2d_lattice u_lattice (
        .aclk     (aclk),
        .ld       (ld),
        .pos_x    (s_pos_x),
        .pos_z    (s_pos_z),
        .inv_cell (s_inv_cell),
        .salt     (s_salt),
        .cell_x   (cell_x),
        .cell_z   (cell_z),
        .salt_out (salt_s0),
        .smooth   (smooth)
    );

    vn2d_hash u_hash (
        .aclk    (aclk),
        .ld      (ld),
        .cell_x  (cell_x),
        .cell_z  (cell_z),
        .salt    (salt_s0),
        .corners (corners)
    );

    vn2d_blend u_blend (
        .aclk        (aclk),
        .ld          (ld),
        .corners     (corners),
        .smooth      (smooth),
        .noise_value (m_noise_value)
    );

`ifndef ASSERT_OFF
    // A full pipeline with a stalled receiver must not take another transaction.
    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (&v_reg && !m_ready) |-> !s_ready)
        else $error("input accepted while the pipeline is full and stalled");

    // An empty output slot means the whole pipeline can advance.
    a_empty_out_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled although the output stage is empty");

    // One accepted transaction without a delivered one adds exactly one sample in flight.
    a_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !(m_valid && m_ready)) |=>
        ($countones(v_reg) == $past($countones(v_reg)) + 1))
        else $error("samples in flight did not grow by one");
`endif

endmodule

`default_nettype wire
